[hw/rtl/rctc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rctc_pkg
// Shared types and constants of the rule contingency table counter.
// ----------------------------------------------------------------------------
package rctc_pkg;

    localparam int MAX_PREDICATES = 8;
    localparam int VALUE_WIDTH    = 8;
    localparam int BYTE_WIDTH     = 8;
    localparam int COUNT_WIDTH    = 32;
    localparam int OUT_WIDTH      = 32;
    localparam int NUM_SLOTS      = 4;
    localparam int LEN_WIDTH      = 4;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 64;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        SLOT_BOTH      = 2'd0,
        SLOT_CONC_ONLY = 2'd1,
        SLOT_PREM_ONLY = 2'd2,
        SLOT_NEITHER   = 2'd3
    } t_slot;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_RULE_LENGTH        = 3'd0,
        CFG_PREMISE_VALUES     = 3'd1,
        CFG_PREMISE_NEGATED    = 3'd2,
        CFG_EXEMPT_MASK        = 3'd3,
        CFG_EXEMPT_IN_USE      = 3'd4,
        CFG_CONCLUSION_VALUE   = 3'd5,
        CFG_CONCLUSION_NEGATED = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [LEN_WIDTH-1:0]                       rule_length;
        logic [MAX_PREDICATES*BYTE_WIDTH-1:0]       premise_values;
        logic [MAX_PREDICATES-1:0]                  premise_negated;
        logic [MAX_PREDICATES-1:0]                  exempt_mask;
        logic                                       exempt_in_use;
        logic [BYTE_WIDTH-1:0]                      conclusion_value;
        logic                                       conclusion_negated;
    } t_cfg;

    typedef struct packed {
        logic  counted;
        t_slot slot;
    } t_eval;

    typedef logic [NUM_SLOTS-1:0][COUNT_WIDTH-1:0] t_count_arr;

endpackage

[hw/rtl/rctc_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rctc_eval
// Evaluates the rule on one object: premise and conclusion tests, skip
// conditions, and the table slot to bump.
// ----------------------------------------------------------------------------
module rctc_eval (
    input  rctc_pkg::t_cfg                                          i_cfg,
    input  logic [rctc_pkg::MAX_PREDICATES*rctc_pkg::BYTE_WIDTH-1:0] i_object_values,
    input  logic [rctc_pkg::MAX_PREDICATES-1:0]                     i_object_present,
    input  logic [rctc_pkg::BYTE_WIDTH-1:0]                         i_conclusion_seen,
    input  logic                                                    i_conclusion_present,
    output rctc_pkg::t_eval                                         o_eval
);
    import rctc_pkg::*;

    logic [MAX_PREDICATES-1:0] w_active;
    logic [MAX_PREDICATES-1:0] w_fail;
    logic [MAX_PREDICATES-1:0] w_blocked;
    logic                      w_usable;
    logic                      w_premise;
    logic                      w_conc;

    always_comb begin
        for (int i = 0; i < MAX_PREDICATES; i++) begin
            // rule_length above the predicate count simply enables all of them
            w_active[i] = (i_cfg.rule_length > LEN_WIDTH'(i));
            w_fail[i]   = w_active[i] & i_object_present[i] &
                          ((i_object_values[i*BYTE_WIDTH +: VALUE_WIDTH] ==
                            i_cfg.premise_values[i*BYTE_WIDTH +: VALUE_WIDTH]) ==
                           i_cfg.premise_negated[i]);
            // absent attribute, or failure outside the tested subset
            w_blocked[i] = w_active[i] &
                           (~i_object_present[i] |
                            (w_fail[i] & i_cfg.exempt_in_use & ~i_cfg.exempt_mask[i]));
        end
        w_usable  = ~(|w_blocked) & i_conclusion_present;
        w_premise = ~(|w_fail);
        w_conc    = (i_conclusion_seen[VALUE_WIDTH-1:0] ==
                     i_cfg.conclusion_value[VALUE_WIDTH-1:0]) != i_cfg.conclusion_negated;

        o_eval.counted = w_usable;
        if (w_premise) begin
            o_eval.slot = w_conc ? SLOT_BOTH : SLOT_PREM_ONLY;
        end else begin
            o_eval.slot = w_conc ? SLOT_CONC_ONLY : SLOT_NEITHER;
        end
    end

endmodule

[hw/rtl/rctc_counts.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rctc_counts
// The four saturating table counters with a synchronous clear.
// ----------------------------------------------------------------------------
module rctc_counts (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_update,
    input  logic                 i_clear,
    input  rctc_pkg::t_eval      i_eval,
    output rctc_pkg::t_count_arr o_counts
);
    import rctc_pkg::*;

    t_count_arr r_count;
    t_count_arr n_count;

    always_comb begin
        n_count = r_count;
        if (i_update) begin
            if (i_clear) begin
                n_count = '0;
            end else if (i_eval.counted && (r_count[i_eval.slot] != COUNT_MAX)) begin
                n_count[i_eval.slot] = r_count[i_eval.slot] + COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_counts = r_count;

endmodule

[hw/rtl/rule_contingency_table_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rule_contingency_table_counter
// Path: input register, then rule evaluation and counter update into the
//   result register. Throughput: one item per cycle while the output is not
//   stalled; the input register frees as the result register is loaded, so
//   a stalled output holds two items inside.
// Reset: synchronous active low; clears config registers, counters, valids.
// ----------------------------------------------------------------------------
module rule_contingency_table_counter (
    input  logic                                                    i_clk,
    input  logic                                                    i_rst_n,
    // configuration
    input  logic                                                    i_cfg_valid,
    output logic                                                    o_cfg_ready,
    input  logic [rctc_pkg::CFG_IDX_WIDTH-1:0]                      i_cfg_index,
    input  logic [rctc_pkg::CFG_DATA_WIDTH-1:0]                     i_cfg_data,
    // input items
    input  logic                                                    i_in_valid,
    output logic                                                    o_in_ready,
    input  logic                                                    i_command,
    input  logic [rctc_pkg::MAX_PREDICATES*rctc_pkg::BYTE_WIDTH-1:0] i_object_values,
    input  logic [rctc_pkg::MAX_PREDICATES-1:0]                     i_object_present,
    input  logic [rctc_pkg::BYTE_WIDTH-1:0]                         i_conclusion_seen,
    input  logic                                                    i_conclusion_present,
    // results
    output logic                                                    o_out_valid,
    input  logic                                                    i_out_ready,
    output logic [rctc_pkg::OUT_WIDTH-1:0]                          o_count_both,
    output logic [rctc_pkg::OUT_WIDTH-1:0]                          o_count_conclusion_only,
    output logic [rctc_pkg::OUT_WIDTH-1:0]                          o_count_premise_only,
    output logic [rctc_pkg::OUT_WIDTH-1:0]                          o_count_neither,
    output logic                                                    o_object_counted
);
    import rctc_pkg::*;

    t_cfg r_cfg;

    logic                                 r_in_valid;
    logic                                 r_in_command;
    logic [MAX_PREDICATES*BYTE_WIDTH-1:0] r_in_values;
    logic [MAX_PREDICATES-1:0]            r_in_present;
    logic [BYTE_WIDTH-1:0]                r_in_conc_seen;
    logic                                 r_in_conc_present;

    logic       r_out_valid;
    logic       r_out_counted;
    logic       w_move;
    t_eval      w_eval;
    t_count_arr w_counts;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RULE_LENGTH:        r_cfg.rule_length <= i_cfg_data[LEN_WIDTH-1:0];
                CFG_PREMISE_VALUES:     r_cfg.premise_values <=
                                            i_cfg_data[MAX_PREDICATES*BYTE_WIDTH-1:0];
                CFG_PREMISE_NEGATED:    r_cfg.premise_negated <=
                                            i_cfg_data[MAX_PREDICATES-1:0];
                CFG_EXEMPT_MASK:        r_cfg.exempt_mask <= i_cfg_data[MAX_PREDICATES-1:0];
                CFG_EXEMPT_IN_USE:      r_cfg.exempt_in_use <= i_cfg_data[0];
                CFG_CONCLUSION_VALUE:   r_cfg.conclusion_value <= i_cfg_data[BYTE_WIDTH-1:0];
                CFG_CONCLUSION_NEGATED: r_cfg.conclusion_negated <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage hand-off: item leaves the input register when the result slot is free
    assign w_move     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_command      <= i_command;
            r_in_values       <= i_object_values;
            r_in_present      <= i_object_present;
            r_in_conc_seen    <= i_conclusion_seen;
            r_in_conc_present <= i_conclusion_present;
        end
    end

    rctc_eval u_eval (
        .i_cfg                (r_cfg),
        .i_object_values      (r_in_values),
        .i_object_present     (r_in_present),
        .i_conclusion_seen    (r_in_conc_seen),
        .i_conclusion_present (r_in_conc_present),
        .o_eval               (w_eval)
    );

    // counters only change on a hand-off, so they double as the result payload
    rctc_counts u_counts (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_move),
        .i_clear  (r_in_command == CMD_CLEAR),
        .i_eval   (w_eval),
        .o_counts (w_counts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_counted <= (r_in_command == CMD_COUNT) && w_eval.counted;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_object_counted        = r_out_counted;
    assign o_count_both            = w_counts[SLOT_BOTH][OUT_WIDTH-1:0];
    assign o_count_conclusion_only = w_counts[SLOT_CONC_ONLY][OUT_WIDTH-1:0];
    assign o_count_premise_only    = w_counts[SLOT_PREM_ONLY][OUT_WIDTH-1:0];
    assign o_count_neither         = w_counts[SLOT_NEITHER][OUT_WIDTH-1:0];

    // clear command leaves an all-zero table
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && (r_in_command == CMD_CLEAR)) |=> (w_counts == '0))
        else $error("table not cleared");

    // table only moves when an item is handed to the result register
    a_counts_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_move |=> $stable(w_counts))
        else $error("counters changed without an item");

    // input side only stalls when a result is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

    // a skipped count object leaves the table unchanged
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && (r_in_command == CMD_COUNT) && !w_eval.counted) |=> $stable(w_counts))
        else $error("skipped object changed the table");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the rule contingency table counter. Directed objects exercise each
// rule case (absent attributes, tested subset in and out of use, empty
// subset, oversize and zero rule length, negated tests, clear), then random
// phases reload the rule and stream mostly well-formed objects. A scoreboard
// predicts every result table and compares it field by field.
// ----------------------------------------------------------------------------
module tb;
    import rctc_pkg::*;

    typedef struct packed {
        logic                                 command;
        logic [MAX_PREDICATES*BYTE_WIDTH-1:0] values;
        logic [MAX_PREDICATES-1:0]            present;
        logic [BYTE_WIDTH-1:0]                conc_seen;
        logic                                 conc_present;
    } t_object;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] both;
        logic [OUT_WIDTH-1:0] conc_only;
        logic [OUT_WIDTH-1:0] prem_only;
        logic [OUT_WIDTH-1:0] neither;
        logic                 counted;
    } t_table;

    class table_tracker;
        t_cfg                   rule;
        logic [COUNT_WIDTH-1:0] tally [NUM_SLOTS];
        t_table                 expected_tables [$];
        int                     errors;
        int                     objects;
        int                     clears;
        int                     hits;
        int                     results;
        int                     reg_writes;

        function new();
            rule = '0;
            foreach (tally[s]) tally[s] = '0;
            errors = 0;
            objects = 0;
            clears = 0;
            hits = 0;
            results = 0;
            reg_writes = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_DATA_WIDTH-1:0] data);
            reg_writes++;
            case (idx)
                CFG_RULE_LENGTH:        rule.rule_length = data[LEN_WIDTH-1:0];
                CFG_PREMISE_VALUES:     rule.premise_values = data;
                CFG_PREMISE_NEGATED:    rule.premise_negated = data[MAX_PREDICATES-1:0];
                CFG_EXEMPT_MASK:        rule.exempt_mask = data[MAX_PREDICATES-1:0];
                CFG_EXEMPT_IN_USE:      rule.exempt_in_use = data[0];
                CFG_CONCLUSION_VALUE:   rule.conclusion_value = data[BYTE_WIDTH-1:0];
                CFG_CONCLUSION_NEGATED: rule.conclusion_negated = data[0];
                default: ;
            endcase
        endfunction

        function t_table tally_object(t_object obj);
            t_table res;
            int     len;
            logic   usable;
            logic   premise;
            logic   holds;
            logic   conc;
            t_slot  slot;
            len = (rule.rule_length > MAX_PREDICATES) ? MAX_PREDICATES
                                                      : int'(rule.rule_length);
            usable = 1'b1;
            premise = 1'b1;
            res.counted = 1'b0;
            if (obj.command == CMD_CLEAR) begin
                foreach (tally[s]) tally[s] = '0;
            end else begin
                for (int i = 0; i < MAX_PREDICATES; i++) begin
                    if (i < len && usable) begin
                        if (!obj.present[i]) begin
                            usable = 1'b0;
                        end else begin
                            holds = (obj.values[i*BYTE_WIDTH +: VALUE_WIDTH] ==
                                     rule.premise_values[i*BYTE_WIDTH +: VALUE_WIDTH])
                                    != rule.premise_negated[i];
                            // a failure outside the tested subset drops the object
                            if (!holds) begin
                                if (rule.exempt_in_use && !rule.exempt_mask[i])
                                    usable = 1'b0;
                                else
                                    premise = 1'b0;
                            end
                        end
                    end
                end
                if (usable && obj.conc_present) begin
                    conc = (obj.conc_seen[VALUE_WIDTH-1:0] ==
                            rule.conclusion_value[VALUE_WIDTH-1:0]) != rule.conclusion_negated;
                    if (premise)
                        slot = conc ? SLOT_BOTH : SLOT_PREM_ONLY;
                    else
                        slot = conc ? SLOT_CONC_ONLY : SLOT_NEITHER;
                    if (tally[slot] != COUNT_MAX)
                        tally[slot] = tally[slot] + 1'b1;
                    res.counted = 1'b1;
                end
            end
            res.both      = OUT_WIDTH'(tally[SLOT_BOTH]);
            res.conc_only = OUT_WIDTH'(tally[SLOT_CONC_ONLY]);
            res.prem_only = OUT_WIDTH'(tally[SLOT_PREM_ONLY]);
            res.neither   = OUT_WIDTH'(tally[SLOT_NEITHER]);
            return res;
        endfunction

        function void note_object(t_object obj);
            t_table res;
            res = tally_object(obj);
            objects++;
            if (obj.command == CMD_CLEAR) clears++;
            if (res.counted) hits++;
            expected_tables.insert(expected_tables.size(), res);
        endfunction

        function void compare_field(string what, logic [OUT_WIDTH-1:0] want,
                                    logic [OUT_WIDTH-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
            end
        endfunction

        function void check_table(t_table got);
            t_table want;
            if (expected_tables.size() == 0) begin
                errors++;
                $display("%0t ns: result with no object outstanding, expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_tables.pop_front();
            results++;
            compare_field("count_both", want.both, got.both);
            compare_field("count_conclusion_only", want.conc_only, got.conc_only);
            compare_field("count_premise_only", want.prem_only, got.prem_only);
            compare_field("count_neither", want.neither, got.neither);
            compare_field("object_counted", OUT_WIDTH'(want.counted), OUT_WIDTH'(got.counted));
        endfunction

        function int pending();
            return expected_tables.size();
        endfunction
    endclass

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]             i_cfg_index;
    logic [CFG_DATA_WIDTH-1:0]            i_cfg_data;
    logic                                 i_in_valid;
    logic                                 o_in_ready;
    logic                                 i_command;
    logic [MAX_PREDICATES*BYTE_WIDTH-1:0] i_object_values;
    logic [MAX_PREDICATES-1:0]            i_object_present;
    logic [BYTE_WIDTH-1:0]                i_conclusion_seen;
    logic                                 i_conclusion_present;
    logic                                 o_out_valid;
    logic                                 i_out_ready;
    logic [OUT_WIDTH-1:0]                 o_count_both;
    logic [OUT_WIDTH-1:0]                 o_count_conclusion_only;
    logic [OUT_WIDTH-1:0]                 o_count_premise_only;
    logic [OUT_WIDTH-1:0]                 o_count_neither;
    logic                                 o_object_counted;

    table_tracker tracker;
    int           idle_pct;
    bit           calm;
    bit           long_hold_req;

    rule_contingency_table_counter dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_valid             (i_cfg_valid),
        .o_cfg_ready             (o_cfg_ready),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data),
        .i_in_valid              (i_in_valid),
        .o_in_ready              (o_in_ready),
        .i_command               (i_command),
        .i_object_values         (i_object_values),
        .i_object_present        (i_object_present),
        .i_conclusion_seen       (i_conclusion_seen),
        .i_conclusion_present    (i_conclusion_present),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_count_both            (o_count_both),
        .o_count_conclusion_only (o_count_conclusion_only),
        .o_count_premise_only    (o_count_premise_only),
        .o_count_neither         (o_count_neither),
        .o_object_counted        (o_object_counted)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Builds a count object whose predicates fail exactly where fail is set.
    function automatic t_object shape_object(t_cfg c, logic [7:0] fail, logic [7:0] present,
                                             logic conc_hold, logic conc_present);
        t_object               obj;
        int                    len;
        logic [BYTE_WIDTH-1:0] want;
        logic [BYTE_WIDTH-1:0] flip;
        len = (c.rule_length > MAX_PREDICATES) ? MAX_PREDICATES : int'(c.rule_length);
        obj.command = CMD_COUNT;
        obj.present = present;
        obj.conc_present = conc_present;
        for (int i = 0; i < MAX_PREDICATES; i++) begin
            want = c.premise_values[i*BYTE_WIDTH +: BYTE_WIDTH];
            flip = BYTE_WIDTH'($urandom_range(1, (1 << VALUE_WIDTH) - 1));
            if (i < len)
                obj.values[i*BYTE_WIDTH +: BYTE_WIDTH] =
                    (fail[i] ^ c.premise_negated[i]) ? want ^ flip : want;
            else
                obj.values[i*BYTE_WIDTH +: BYTE_WIDTH] = BYTE_WIDTH'($urandom);
        end
        flip = BYTE_WIDTH'($urandom_range(1, (1 << VALUE_WIDTH) - 1));
        obj.conc_seen = (!conc_hold ^ c.conclusion_negated) ? c.conclusion_value ^ flip
                                                            : c.conclusion_value;
        return obj;
    endfunction

    function automatic t_object random_object(t_cfg c);
        t_object    obj;
        logic [7:0] fail;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            obj.command      = (pick < 4) ? CMD_CLEAR : CMD_COUNT;
            obj.values       = {$urandom, $urandom};
            obj.present      = 8'($urandom);
            obj.conc_seen    = 8'($urandom);
            obj.conc_present = 1'($urandom);
        end else begin
            fail = '0;
            for (int i = 0; i < MAX_PREDICATES; i++)
                fail[i] = ($urandom_range(0, 4) == 0);
            obj = shape_object(c, fail, 8'hFF, 1'($urandom_range(0, 1)),
                               $urandom_range(0, 11) != 0);
            if ($urandom_range(0, 7) == 0)
                obj.present[$urandom_range(0, 7)] = 1'b0;
        end
        return obj;
    endfunction

    function automatic t_cfg random_rule(int ph);
        t_cfg c;
        c.premise_values     = {$urandom, $urandom};
        c.premise_negated    = 8'($urandom);
        c.exempt_in_use      = 1'($urandom);
        c.conclusion_value   = 8'($urandom);
        c.conclusion_negated = 1'($urandom);
        c.rule_length        = ($urandom_range(0, 9) < 6) ? 4'($urandom_range(1, 8))
                                                          : 4'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
            0: c.exempt_mask = 8'h00;
            1: c.exempt_mask = 8'hFF;
            default: c.exempt_mask = 8'($urandom);
        endcase
        // the first two phases sit at the register extremes
        if (ph == 0) begin
            c = '1;
            c.rule_length = 4'd8;
        end else if (ph == 1) begin
            c = '0;
            c.rule_length = 4'd15;
        end
        return c;
    endfunction

    task automatic send_object(input t_object obj);
        i_in_valid           <= 1'b1;
        i_command            <= obj.command;
        i_object_values      <= obj.values;
        i_object_present     <= obj.present;
        i_conclusion_seen    <= obj.conc_seen;
        i_conclusion_present <= obj.conc_present;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_object(obj);
    endtask

    task automatic maybe_gap();
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_WIDTH-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_register(idx, data);
    endtask

    // Writes every register while the block is idle; unused upper bits carry noise.
    task automatic load_rule(input t_cfg c);
        logic [CFG_DATA_WIDTH-1:0] junk;
        junk = {$urandom, $urandom};
        wait_all_results();
        write_register(CFG_RULE_LENGTH, {junk[63:LEN_WIDTH], c.rule_length});
        write_register(CFG_PREMISE_VALUES, c.premise_values);
        write_register(CFG_PREMISE_NEGATED, {junk[63:8], c.premise_negated});
        write_register(CFG_EXEMPT_MASK, {junk[63:8], ~c.premise_negated ^ c.exempt_mask
                                         ^ ~c.premise_negated});
        write_register(CFG_EXEMPT_IN_USE, {junk[63:1], c.exempt_in_use});
        write_register(CFG_CONCLUSION_VALUE, {junk[63:8], c.conclusion_value});
        write_register(CFG_CONCLUSION_NEGATED, {junk[63:1], c.conclusion_negated});
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: checks accepted tables and paces ready.
    initial begin
        int     stall_left;
        t_table got;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                got.both      = o_count_both;
                got.conc_only = o_count_conclusion_only;
                got.prem_only = o_count_premise_only;
                got.neither   = o_count_neither;
                got.counted   = o_object_counted;
                tracker.check_table(got);
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = 300;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) i_out_ready <= 1'b1;
            end else if (!calm && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(1, 6);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Timeout at %0t ns", $time);
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_cfg    c;
        t_object obj;
        tracker = new();
        idle_pct = 25;
        calm = 1'b0;
        long_hold_req = 1'b0;
        i_rst_n              <= 1'b0;
        i_cfg_valid          <= 1'b0;
        i_cfg_index          <= '0;
        i_cfg_data           <= '0;
        i_in_valid           <= 1'b0;
        i_command            <= CMD_COUNT;
        i_object_values      <= '0;
        i_object_present     <= '0;
        i_conclusion_seen    <= '0;
        i_conclusion_present <= 1'b0;
        i_out_ready          <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset rule: zero length, so the premise holds vacuously
        send_object(shape_object(tracker.rule, 8'h00, 8'h00, 1'b1, 1'b1));
        maybe_gap();
        send_object(shape_object(tracker.rule, 8'h00, 8'hFF, 1'b0, 1'b1));
        maybe_gap();
        send_object(shape_object(tracker.rule, 8'h00, 8'hFF, 1'b1, 1'b0));
        obj = '1;
        obj.command = CMD_CLEAR;
        send_object(obj);

        c = '0;
        c.rule_length      = 4'd3;
        c.premise_values   = 64'hFFFF_FFFF_FF00_A55A;
        c.premise_negated  = 8'b0000_0010;
        c.conclusion_value = 8'hFF;
        load_rule(c);
        send_object(shape_object(tracker.rule, 8'h00, 8'hFF, 1'b1, 1'b1));
        maybe_gap();
        send_object(shape_object(tracker.rule, 8'h00, 8'hFF, 1'b0, 1'b1));
        send_object(shape_object(tracker.rule, 8'h01, 8'hFF, 1'b1, 1'b1));
        maybe_gap();
        send_object(shape_object(tracker.rule, 8'h04, 8'hFF, 1'b0, 1'b1));
        send_object(shape_object(tracker.rule, 8'h00, 8'hFD, 1'b1, 1'b1));
        send_object(shape_object(tracker.rule, 8'h00, 8'hFF, 1'b1, 1'b0));
        // attributes past the rule length may be absent
        send_object(shape_object(tracker.rule, 8'h00, 8'h07, 1'b1, 1'b1));

        c = '0;
        c.rule_length        = 4'd8;
        c.premise_values     = '1;
        c.premise_negated    = 8'hF0;
        c.exempt_in_use      = 1'b1;
        c.exempt_mask        = 8'h0F;
        c.conclusion_negated = 1'b1;
        load_rule(c);
        send_object(shape_object(tracker.rule, 8'h00, 8'hFF, 1'b1, 1'b1));
        send_object(shape_object(tracker.rule, 8'h02, 8'hFF, 1'b1, 1'b1));
        maybe_gap();
        send_object(shape_object(tracker.rule, 8'h40, 8'hFF, 1'b1, 1'b1));
        send_object(shape_object(tracker.rule, 8'h42, 8'hFF, 1'b0, 1'b1));

        // subset in use but empty; oversize rule length
        c = '0;
        c.rule_length      = 4'd15;
        c.exempt_in_use    = 1'b1;
        c.conclusion_value = 8'h80;
        load_rule(c);
        send_object(shape_object(tracker.rule, 8'h00, 8'hFF, 1'b1, 1'b1));
        send_object(shape_object(tracker.rule, 8'h80, 8'hFF, 1'b1, 1'b1));
        obj = '0;
        obj.command = CMD_CLEAR;
        send_object(obj);
        send_object(shape_object(tracker.rule, 8'h00, 8'hFF, 1'b0, 1'b1));

        c = random_rule(2);
        c.rule_length     = 4'd8;
        c.premise_negated = 8'hFF;
        c.exempt_in_use   = 1'b0;
        c.exempt_mask     = 8'hFF;
        load_rule(c);
        send_object(shape_object(tracker.rule, 8'h80, 8'hFF, 1'b0, 1'b1));
        send_object(shape_object(tracker.rule, 8'h00, 8'hFF, 1'b1, 1'b1));
        send_object('0);

        for (int ph = 0; ph < 12; ph++) begin
            load_rule(random_rule(ph));
            calm = (ph >= 10);
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 40;
            endcase
            if (ph == 3) idle_pct = 15;
            if (calm) idle_pct = 0;
            for (int n = 0; n < 135; n++) begin
                // long output stall while objects keep coming
                if (ph == 3 && n == 20) long_hold_req = 1'b1;
                if (ph == 5 && n == 60) wait_all_results();
                send_object(random_object(tracker.rule));
                maybe_gap();
            end
        end

        wait_all_results();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d objects (%0d clears, %0d counted) under %0d register writes,",
                 tracker.objects, tracker.clears, tracker.hits, tracker.reg_writes);
        $display("with %0d result tables checked and %0d mismatches.",
                 tracker.results, tracker.errors);
        if (tracker.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
